// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset
`define CHK_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent
`define CHK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/b64d_pkg.sv -----
// Types, codes and helpers for the base64 stream decoder
package b64d_pkg;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_BADCHAR = 2'd1;
    localparam status_t ST_FORMAT  = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Input transaction
    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        status_t    status;
        logic       last;
    } out_item_t;

    // Work handed from front to back: a decoded quad or a status result
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  count;
        logic        is_status;
        status_t     status;
        logic        last;
    } op_t;

    // Map a character to {valid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            d = c - 8'h41;
            r = {1'b1, d[5:0]};
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = c - 8'h61 + 8'd26;
            r = {1'b1, d[5:0]};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30 + 8'd52;
            r = {1'b1, d[5:0]};
        end
        else if (c == 8'h2B)
        begin
            r = {1'b1, 6'd62};
        end
        else if (c == 8'h2F)
        begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// ----- rtl/b64d_queue.sv -----
// Short queue of decode operations between front and back
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  b64d_pkg::op_t  wr_op,
    output logic           full,
    input  logic           rd_en,
    output b64d_pkg::op_t  rd_op,
    output logic           nonempty
);
    import b64d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CNT_FULL);
    assign nonempty = (cnt_reg != '0);
    assign rd_op    = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

// ----- rtl/b64d_front.sv -----
// Front end: classifies characters, gathers quads and tracks errors
module b64d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  b64d_pkg::in_item_t item,
    output logic               op_valid,
    output b64d_pkg::op_t      op
);
    import b64d_pkg::*;

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    status_t     err_reg, err_next;

    logic        is_pad;
    logic [6:0]  sx;
    logic [5:0]  v;
    status_t     err;
    logic [1:0]  pad_upd;

    assign is_pad = (item.in_char == PAD_CHAR);
    assign sx     = sextet_of(item.in_char);
    assign v      = is_pad ? 6'd0 : sx[5:0];

    // Classify the character and decide the next state and the operation
    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        op_valid = 1'b0;
        op       = '0;
        err      = ST_OK;
        pad_upd  = pad_reg;

        if (err_reg == ST_OK)
        begin
            if (is_pad)
            begin
                if (pos_reg < 2'd2)
                begin
                    err = ST_FORMAT;
                end
                else
                begin
                    pad_upd = pad_reg + 1'b1;
                end
            end
            else if (!sx[6])
            begin
                err = ST_BADCHAR;
            end
            else if (pad_reg != 2'd0)
            begin
                err = ST_FORMAT;
            end

            if (err == ST_OK)
            begin
                if (pos_reg != 2'd3)
                begin
                    acc_next = {acc_reg[11:0], v};
                    pos_next = pos_reg + 1'b1;
                    pad_next = pad_upd;
                    if (item.end_of_text)
                    begin
                        err = ST_FORMAT;
                    end
                end
                else
                begin
                    if (pad_upd != 2'd0 && !item.end_of_text)
                    begin
                        err = ST_FORMAT;
                    end
                    else
                    begin
                        op_valid     = 1'b1;
                        op.triple    = {acc_reg, v};
                        op.count     = 2'd3 - pad_upd;
                        op.is_status = 1'b0;
                        op.status    = ST_OK;
                        op.last      = item.end_of_text;
                    end
                    acc_next = '0;
                    pos_next = '0;
                    pad_next = '0;
                end
            end
            err_next = err;
        end

        // End of text: report a latched or new error and return to reset state
        if (item.end_of_text)
        begin
            if (err_next != ST_OK)
            begin
                op_valid     = 1'b1;
                op           = '0;
                op.count     = 2'd1;
                op.is_status = 1'b1;
                op.status    = err_next;
                op.last      = 1'b1;
            end
            acc_next = '0;
            pos_next = '0;
            pad_next = '0;
            err_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            pad_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
        end
    end

endmodule

// ----- rtl/b64d_back.sv -----
// Back end: expands operations into result transactions, one per cycle while the output is not stalled
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_ready,
    input  b64d_pkg::op_t       op_head,
    output logic                op_take,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::out_item_t result
);
    import b64d_pkg::*;

    logic      cur_valid_reg, cur_valid_next;
    op_t       cur_op_reg, cur_op_next;
    logic [1:0] idx_reg, idx_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic      can_load, emit, at_end, finish;
    out_item_t res;

    assign can_load = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && can_load;
    assign at_end   = cur_op_reg.is_status || (idx_reg == cur_op_reg.count - 2'd1);
    assign finish   = emit && at_end;
    assign op_take  = op_ready && (!cur_valid_reg || finish);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // Build the result for the current index
    always_comb
    begin
        res = '0;
        if (cur_op_reg.is_status)
        begin
            res.status = cur_op_reg.status;
            res.last   = 1'b1;
        end
        else
        begin
            case (idx_reg)
                2'd0:    res.out_byte = cur_op_reg.triple[23:16];
                2'd1:    res.out_byte = cur_op_reg.triple[15:8];
                2'd2:    res.out_byte = cur_op_reg.triple[7:0];
                default: res.out_byte = 8'd0;
            endcase
            res.byte_valid = 1'b1;
            res.status     = ST_OK;
            res.last       = cur_op_reg.last && at_end;
        end
    end

    // Advance through the operation and refill from the queue
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_op_next    = cur_op_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
            idx_next       = idx_reg + 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        if (op_take)
        begin
            cur_valid_next = 1'b1;
            cur_op_next    = op_head;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        cur_op_reg <= cur_op_next;
        out_reg    <= out_next;
    end

endmodule

// ----- rtl/base64_stream_decoder_top.sv -----
// Top level of the base64 stream decoder
//
// Input channel: one character per transaction on char_item, taken at a
// rising edge with push high and full low; end_of_text marks the final
// character of a string. Result channel: the oldest result sits on
// result_item while empty is low and is taken at an edge with pop high.
// Each completed quad gives one to three byte results; a string with an
// error gives a single status result with last set at its final character.
// A result travels from the queue, written at the edge that takes the character
// that causes it, through the operation register to the output register.
// Throughput: one character per cycle while full is low; the back end drains one
// result per cycle while pop is high, so three results per four characters keep the queue from filling.
// If the receiver stalls, the queue fills and full rises after DEPTH
// operations are waiting. Reset clears the quad state, the error latch,
// the queue and the output register; no result is pending after reset.
module base64_stream_decoder_top #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::in_item_t  char_item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::out_item_t result_item
);
    import b64d_pkg::*;

    logic accept;
    logic op_valid;
    op_t  op;
    op_t  op_head;
    logic op_ready;
    logic op_take;

    assign accept = push && !full;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (char_item),
        .op_valid (op_valid),
        .op       (op)
    );

    b64d_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && op_valid),
        .wr_op    (op),
        .full     (full),
        .rd_en    (op_take),
        .rd_op    (op_head),
        .nonempty (op_ready)
    );

    b64d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_ready (op_ready),
        .op_head  (op_head),
        .op_take  (op_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result_item)
    );

endmodule

// ----- rtl/b64d_checker.sv -----
// Port-level checker for the base64 stream decoder, with its bind
`include "assert_macros.svh"

module b64d_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input b64d_pkg::in_item_t  char_item,
    input logic                empty,
    input logic                pop,
    input b64d_pkg::out_item_t result_item
);
    import b64d_pkg::*;

    // A stalled result stays in place
    `CHK_NEXT(a_hold, !empty && !pop, !empty && $stable(result_item),
        "result changed while stalled")

    // Byte results never carry an error status
    `CHK_IMPLY(a_byte_ok, !empty && result_item.byte_valid, result_item.status == ST_OK,
        "byte result with error status")

    // A result without a byte is the final error report of a string
    `CHK_IMPLY(a_err_rpt, !empty && !result_item.byte_valid,
        result_item.last && result_item.out_byte == 8'd0 &&
        (result_item.status == ST_BADCHAR || result_item.status == ST_FORMAT),
        "malformed status result")

    // A waiting result is fully defined
    `CHK_IMPLY(a_out_known, !empty, !$isunknown(result_item), "unknown bits in result")

    // An accepted character is fully defined
    `CHK_IMPLY(a_in_known, push && !full, !$isunknown(char_item),
        "unknown bits in accepted character")

endmodule

bind base64_stream_decoder_top b64d_checker u_chk (.*);
